>>> rtl/core/snapshot_slot_manager_assert.svh
// assertion macros for the snapshot slot manager datapath
// both expect clk and arst_n in scope
`ifndef SNAPSHOT_SLOT_MANAGER_ASSERT_SVH
`define SNAPSHOT_SLOT_MANAGER_ASSERT_SVH

// antecedent and consequent in the same cycle
`define SSM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// consequent in the cycle after the antecedent
`define SSM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/ssm_pkg.sv
package ssm_pkg;

	// fixed field widths
	localparam int SLOT_W  = 4;
	localparam int FRAME_W = 64;
	localparam int MODE_W  = 4;
	localparam int TIME_W  = 32;
	localparam int IN_DATA_W  = 104;
	localparam int OUT_DATA_W = 104;
	localparam int IN_USER_W  = 1;
	localparam int OUT_USER_W = 2;

	// request kinds carried on the input tuser
	localparam logic ACT_SAVE = 1'b0;
	localparam logic ACT_LOAD = 1'b1;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SV_RD,
		ST_SV_WR,
		ST_LD_RD,
		ST_LD_CHK,
		ST_PS_RD,
		ST_PS_WR,
		ST_FIN
	} ssm_state_t;

	// entry memory read address source
	typedef enum logic [1:0] {
		ERD_NONE,
		ERD_HEAD,
		ERD_SEARCH,
		ERD_PUSH
	} ent_rd_sel_t;

	// controller to datapath
	typedef struct packed {
		logic        accept;
		ent_rd_sel_t ent_rd;
		logic        stk_rd;
		logic        save_commit;
		logic        chk;
		logic        push;
		logic        out_load;
	} ssm_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hit;
		logic idx_zero;
		logic idx_end;
		logic out_free;
	} ssm_stat_t;

	// one result request
	typedef struct packed {
		logic               found;
		logic [SLOT_W-1:0]  slot;
		logic               evicted;
		logic [FRAME_W-1:0] frame;
		logic [MODE_W-1:0]  mode;
		logic [TIME_W-1:0]  stime;
	} ssm_result_t;

endpackage

>>> rtl/core/ssm_ctrl.sv
module ssm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_action,
	output logic             in_ready,
	input  ssm_pkg::ssm_stat_t stat,
	output ssm_pkg::ssm_cmd_t  cmd
);
	import ssm_pkg::*;

	ssm_state_t state_q;
	ssm_state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd = '{default: '0, ent_rd: ERD_NONE};
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_nxt = (in_action == ACT_LOAD) ? ST_LD_RD : ST_SV_RD;
				end
			end
			ST_SV_RD: begin
				// fetch both the oldest entry and the top of the free stack
				cmd.ent_rd = ERD_HEAD;
				cmd.stk_rd = 1'b1;
				state_nxt = ST_SV_WR;
			end
			ST_SV_WR: begin
				cmd.save_commit = 1'b1;
				state_nxt = ST_FIN;
			end
			ST_LD_RD: begin
				if (stat.idx_zero) begin
					state_nxt = ST_FIN;
				end else begin
					cmd.ent_rd = ERD_SEARCH;
					state_nxt = ST_LD_CHK;
				end
			end
			ST_LD_CHK: begin
				cmd.chk = 1'b1;
				state_nxt = stat.hit ? ST_PS_RD : ST_LD_RD;
			end
			ST_PS_RD: begin
				if (stat.idx_end) begin
					state_nxt = ST_FIN;
				end else begin
					cmd.ent_rd = ERD_PUSH;
					state_nxt = ST_PS_WR;
				end
			end
			ST_PS_WR: begin
				cmd.push = 1'b1;
				state_nxt = ST_PS_RD;
			end
			ST_FIN: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/core/ssm_datapath.sv
module ssm_datapath #(
	parameter int SLOT_COUNT = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [ssm_pkg::FRAME_W-1:0] in_frame_key,
	input  logic [ssm_pkg::MODE_W-1:0]  in_mode,
	input  logic [ssm_pkg::TIME_W-1:0]  in_time,
	input  ssm_pkg::ssm_cmd_t           cmd,
	output ssm_pkg::ssm_stat_t          stat,
	output logic                        out_valid,
	input  logic                        out_ready,
	output ssm_pkg::ssm_result_t        out_res
);
	import ssm_pkg::*;

	`include "snapshot_slot_manager_assert.svh"

	localparam int SW = $clog2(SLOT_COUNT);
	localparam int CW = $clog2(SLOT_COUNT + 1);

	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		logic [SW-1:0]      slot;
		logic [MODE_W-1:0]  mode;
		logic [TIME_W-1:0]  stime;
	} entry_t;

	// list storage and free stack
	entry_t          ent_mem [SLOT_COUNT];
	logic [SW-1:0]   stk_mem [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] stk_vld_q;

	logic [SW-1:0]   head_q;
	logic [CW-1:0]   lcount_q;
	logic [CW-1:0]   fcount_q;
	logic [CW-1:0]   idx_q;
	logic [CW-1:0]   end_q;

	logic [FRAME_W-1:0] req_key_q;
	logic [MODE_W-1:0]  req_mode_q;
	logic [TIME_W-1:0]  req_time_q;

	entry_t          ent_rd_q;
	logic [SW-1:0]   stk_dat_q;
	logic            stk_dv_q;
	logic [SW-1:0]   stk_da_q;

	ssm_result_t     res_q;
	ssm_result_t     out_q;
	logic            out_valid_q;

	logic [SW-1:0]   ent_ra;
	logic [SW-1:0]   ent_wa;
	logic [SW-1:0]   stk_top;
	logic [SW-1:0]   stk_pop;
	logic [SW-1:0]   slot_new;
	logic [SW-1:0]   head_next;
	logic            evict;
	logic            hit;
	logic            push_ok;
	entry_t          ent_wd;

	// circular list position, sum stays below twice the depth
	function automatic logic [SW-1:0] list_pos(input logic [SW-1:0] h,
		input logic [CW-1:0] off);
		logic [CW:0] sum;
		sum = (CW+1)'(h) + (CW+1)'(off);
		if (sum >= (CW+1)'(SLOT_COUNT)) begin
			sum = sum - (CW+1)'(SLOT_COUNT);
		end
		return SW'(sum);
	endfunction

	// address and write data selection
	always_comb begin
		unique case (cmd.ent_rd)
			ERD_HEAD:   ent_ra = head_q;
			ERD_SEARCH: ent_ra = list_pos(head_q, idx_q - CW'(1));
			ERD_PUSH:   ent_ra = list_pos(head_q, idx_q);
			ERD_NONE:   ent_ra = head_q;
		endcase
	end

	assign evict     = (fcount_q == '0);
	assign stk_top   = evict ? '0 : SW'(fcount_q - CW'(1));
	// a stack entry never written reads as its own index, the slot number it holds after reset
	assign stk_pop   = stk_dv_q ? stk_dat_q : stk_da_q;
	assign slot_new  = evict ? ent_rd_q.slot : stk_pop;
	assign head_next = list_pos(head_q, CW'(1));
	assign ent_wa    = evict ? head_q : list_pos(head_q, lcount_q);
	assign ent_wd    = '{frame: req_key_q, slot: slot_new, mode: req_mode_q,
		stime: req_time_q};
	assign hit       = (ent_rd_q.frame <= req_key_q);
	assign push_ok   = cmd.push && (fcount_q < CW'(SLOT_COUNT));

	// memory ports
	always_ff @(posedge clk) begin
		if (cmd.save_commit) begin
			ent_mem[ent_wa] <= ent_wd;
		end
		if (cmd.ent_rd != ERD_NONE) begin
			ent_rd_q <= ent_mem[ent_ra];
		end
		if (cmd.stk_rd) begin
			stk_dat_q <= stk_mem[stk_top];
			stk_dv_q  <= stk_vld_q[stk_top];
			stk_da_q  <= stk_top;
		end
		if (push_ok) begin
			stk_mem[fcount_q[SW-1:0]] <= ent_rd_q.slot;
		end
	end

	// list and pool control state, each freed slot leaves the list as it joins the stack
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			lcount_q    <= '0;
			fcount_q    <= CW'(SLOT_COUNT);
			stk_vld_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.save_commit) begin
				if (evict) begin
					head_q <= head_next;
				end else begin
					fcount_q <= fcount_q - CW'(1);
					lcount_q <= lcount_q + CW'(1);
				end
			end
			if (push_ok) begin
				fcount_q <= fcount_q + CW'(1);
				lcount_q <= lcount_q - CW'(1);
				stk_vld_q[fcount_q[SW-1:0]] <= 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request, walk index and result registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_key_q  <= in_frame_key;
			req_mode_q <= in_mode;
			req_time_q <= in_time;
			idx_q      <= lcount_q;
			end_q      <= lcount_q;
			res_q      <= '0;
		end
		if (cmd.save_commit) begin
			res_q <= '{found: 1'b1, slot: SLOT_W'(slot_new), evicted: evict,
				frame: '0, mode: '0, stime: '0};
		end
		if (cmd.chk) begin
			if (hit) begin
				res_q <= '{found: 1'b1, slot: SLOT_W'(ent_rd_q.slot), evicted: 1'b0,
					frame: ent_rd_q.frame, mode: ent_rd_q.mode, stime: ent_rd_q.stime};
			end else begin
				idx_q <= idx_q - CW'(1);
			end
		end
		if (cmd.push) begin
			idx_q <= idx_q + CW'(1);
		end
		if (cmd.out_load) begin
			out_q <= res_q;
		end
	end

	// status back to the controller
	assign stat.hit      = hit;
	assign stat.idx_zero = (idx_q == '0);
	assign stat.idx_end  = (idx_q == end_q);
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	// every slot is either on the free stack or held by a list entry
	`SSM_ASSERT_NOW(a_pool_sum, 1'b1,
		((CW+1)'(fcount_q) + (CW+1)'(lcount_q)) == (CW+1)'(SLOT_COUNT),
		"slot pool count mismatch")
	// freeing never overflows the stack
	`SSM_ASSERT_NOW(a_push_room, cmd.push, fcount_q < CW'(SLOT_COUNT),
		"push onto a full free stack")
	// a result is never overwritten before it is taken
	`SSM_ASSERT_NOW(a_out_free, cmd.out_load, !out_valid_q || out_ready,
		"result register overwritten")

endmodule

>>> rtl/core/snapshot_slot_manager.sv
// save: the result is registered after ST_SV_RD, ST_SV_WR and ST_FIN
// load: ST_LD_RD/ST_LD_CHK per entry probed, ST_PS_RD/ST_PS_WR per entry freed, then ST_FIN;
//   each probe and each freed slot costs one entry memory read plus one compare or push
// worst case is a match on the oldest entry; a held result adds its stall
// one request in flight; the next request is taken in the same cycle the result is valid
// arst_n clears the list, refills the free stack (top slot on top) and drops any result
module snapshot_slot_manager #(
	parameter int SLOT_COUNT = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// frame_key, netplay_mode, start_time, zero fill
	input  logic [ssm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// action
	input  logic [ssm_pkg::IN_USER_W-1:0]     s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// slot, restored_frame, restored_mode, restored_time
	output logic [ssm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	// found, evicted
	output logic [ssm_pkg::OUT_USER_W-1:0]    m_axis_tuser
);
	import ssm_pkg::*;

	ssm_cmd_t    cmd;
	ssm_stat_t   stat;
	ssm_result_t res;

	ssm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_action (s_axis_tuser[0]),
		.in_ready  (s_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ssm_datapath #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_frame_key (s_axis_tdata[FRAME_W-1:0]),
		.in_mode      (s_axis_tdata[FRAME_W+MODE_W-1:FRAME_W]),
		.in_time      (s_axis_tdata[FRAME_W+MODE_W+TIME_W-1:FRAME_W+MODE_W]),
		.cmd          (cmd),
		.stat         (stat),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_res      (res)
	);

	// result packing
	assign m_axis_tdata = {res.stime, res.mode, res.frame, res.slot};
	assign m_axis_tuser = {res.evicted, res.found};

endmodule
